// ----- src/dtq_pkg.sv -----
// Shared types, constants and codes of the deadline timer queue.
package dtq_pkg;

    localparam int NUM_TIMERS = 32;
    localparam int SLOT_W     = $clog2(NUM_TIMERS);
    localparam int IDX_W      = $clog2(NUM_TIMERS + 1);
    localparam int TIME_W     = 64;
    localparam int PER_W      = 32;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 80;
    localparam int PADDR_W    = 3;

    localparam logic [PER_W-1:0]  DEFAULT_WINDOW = PER_W'(60 * 60 * 1000);
    localparam logic [TIME_W-1:0] ALL_ONES       = '1;

    typedef logic [NUM_TIMERS-1:0] t_mask;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_CANCEL  = 3'd1,
        OP_REFRESH = 3'd2,
        OP_RESET   = 3'd3,
        OP_QUERY   = 3'd4,
        OP_EXPIRE  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD, S_RD, S_REF, S_RST1, S_RST2, S_WSCAN, S_QSCAN,
        S_QFIN, S_ROLL1, S_ROLL2, S_DSCAN, S_SSCAN, S_FIRE, S_UPD, S_EMIT
    } t_state;

    typedef struct packed {
        logic              en_dl;
        logic              en_per;
        logic [SLOT_W-1:0] addr;
        logic [TIME_W-1:0] dl;
        logic [PER_W-1:0]  per;
    } t_mem_wr;

endpackage

// ----- src/dtq_alu.sv -----
// Shared 64-bit add and subtract unit with borrow output.
module dtq_alu (
    input  dtq_pkg::t_alu_op             i_op,
    input  logic [dtq_pkg::TIME_W-1:0]   i_a,
    input  logic [dtq_pkg::TIME_W-1:0]   i_b,
    output logic [dtq_pkg::TIME_W-1:0]   o_res,
    output logic                         o_borrow
);
    logic                         sub;
    logic [dtq_pkg::TIME_W:0]     sum;

    assign sub = (i_op == dtq_pkg::ALU_SUB);
    assign sum = {1'b0, i_a} + {1'b0, (sub ? ~i_b : i_b)} + {{dtq_pkg::TIME_W{1'b0}}, sub};
    assign o_res    = sum[dtq_pkg::TIME_W-1:0];
    // A subtraction borrows when no carry comes out of the top bit.
    assign o_borrow = sub & ~sum[dtq_pkg::TIME_W];
endmodule

// ----- src/dtq_store.sv -----
// Deadline and period memories with one write port and one registered read port.
module dtq_store (
    input  logic                          i_clk,
    input  dtq_pkg::t_mem_wr              i_wr,
    input  logic [dtq_pkg::SLOT_W-1:0]    i_raddr,
    output logic [dtq_pkg::TIME_W-1:0]    o_rd_dl,
    output logic [dtq_pkg::PER_W-1:0]     o_rd_per
);
    logic [dtq_pkg::TIME_W-1:0] mem_dl  [dtq_pkg::NUM_TIMERS];
    logic [dtq_pkg::PER_W-1:0]  mem_per [dtq_pkg::NUM_TIMERS];

    always_ff @(posedge i_clk) begin
        if (i_wr.en_dl) begin
            mem_dl[i_wr.addr] <= i_wr.dl;
        end
        if (i_wr.en_per) begin
            mem_per[i_wr.addr] <= i_wr.per;
        end
        o_rd_dl  <= mem_dl[i_raddr];
        o_rd_per <= mem_per[i_raddr];
    end
endmodule

// ----- src/deadline_timer_queue.sv -----
// Top level of the deadline timer queue: sequencer, slot flags and ports.
//
//  channel  | direction | signals                          | meaning
//  s stream | in        | i_s_tvalid o_s_tready tdata tuser | one command transaction
//  m stream | out       | o_m_tvalid i_m_tready tdata tlast | result transactions
//  apb      | in/out    | i_psel i_penable i_pwrite ...    | rollover window register
//
// Cancel and codes without meaning go straight to the result; refresh first reads
// the slot (S_RD, S_REF). Add passes S_ADD, reset S_RD, S_RST1 and S_RST2, each then
// with one scan of all slots (only when no wakeup is pending); query scans all slots
// and then passes S_QFIN. A scan reads the slots through the single registered read port.
// Expire passes S_ROLL1, S_ROLL2 and the due scan, then one selection scan plus
// S_FIRE, and S_UPD for a recurring timer, for each timer that fires.
// Reset is synchronous and active low; it clears the active and pending flags and the window
// returns to one hour. The memories hold no reset value.
// A result waits in the output register while the sequencer goes on; the
// sequencer stalls only when it must hand over a new result.
module deadline_timer_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata from bit 0: timer_slot(5) interval_ms(32) recurring(1) start_now(1)
    // now_ms(64), zero pad(1)
    input  logic [dtq_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // tuser: operation(3)
    input  logic [2:0]                        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata from bit 0: status(2) result_slot(5) fired(1) delay_ms(64)
    // has_timer(1) wakeup(1), zero pad(6)
    output logic [dtq_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                              o_m_tlast,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [dtq_pkg::PADDR_W-1:0]       i_paddr,
    input  logic [31:0]                       i_pwdata,
    output logic [31:0]                       o_prdata,
    output logic                              o_pready
);
    localparam int N  = dtq_pkg::NUM_TIMERS;
    localparam int SW = dtq_pkg::SLOT_W;
    localparam int IW = dtq_pkg::IDX_W;
    localparam int TW = dtq_pkg::TIME_W;
    localparam int PW = dtq_pkg::PER_W;

    dtq_pkg::t_state       r_state, n_state;
    dtq_pkg::t_op          r_op, n_op;
    logic [SW-1:0]         r_slot, n_slot;
    logic [PW-1:0]         r_interval, n_interval;
    logic                  r_rec, n_rec;
    logic                  r_fnow, n_fnow;
    logic [TW-1:0]         r_now, n_now;
    logic [TW-1:0]         r_prev, n_prev;
    logic [PW-1:0]         r_window;
    logic                  r_pending, n_pending;
    dtq_pkg::t_mask        r_active, n_active;
    dtq_pkg::t_mask        r_repeats, n_repeats;
    dtq_pkg::t_mask        r_due, n_due;
    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_rd_v, n_rd_v;
    logic [SW-1:0]         r_rd_idx, n_rd_idx;
    logic [TW-1:0]         r_best, n_best;
    logic                  r_found, n_found;
    logic [SW-1:0]         r_bidx, n_bidx;
    logic                  r_first, n_first;
    logic [TW-1:0]         r_tmp, n_tmp;
    logic                  r_roll_a, n_roll_a;
    logic                  r_roll, n_roll;
    logic                  r_more, n_more;
    dtq_pkg::t_status      r_res_status, n_res_status;
    logic [SW-1:0]         r_res_slot, n_res_slot;
    logic [TW-1:0]         r_res_delay, n_res_delay;
    logic                  r_res_wake, n_res_wake;

    logic                  r_ov, n_ov;
    dtq_pkg::t_status      r_o_status, n_o_status;
    logic [SW-1:0]         r_o_slot, n_o_slot;
    logic                  r_o_fired, n_o_fired;
    logic [TW-1:0]         r_o_delay, n_o_delay;
    logic                  r_o_ht, n_o_ht;
    logic                  r_o_wake, n_o_wake;
    logic                  r_o_last, n_o_last;

    dtq_pkg::t_alu_op      alu_op;
    logic [TW-1:0]         alu_a, alu_b, alu_res;
    logic                  alu_borrow;
    dtq_pkg::t_mem_wr      mem_wr;
    logic [SW-1:0]         raddr;
    logic [TW-1:0]         rd_dl;
    logic [PW-1:0]         rd_per;

    logic                  s_accept;
    logic                  out_free;
    logic                  scan_done;
    logic                  free_found;
    logic [SW-1:0]         free_slot;
    dtq_pkg::t_mask        bmask;
    dtq_pkg::t_mask        due_left;

    dtq_alu u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    dtq_store u_store (
        .i_clk    (i_clk),
        .i_wr     (mem_wr),
        .i_raddr  (raddr),
        .o_rd_dl  (rd_dl),
        .o_rd_per (rd_per)
    );

    assign o_s_tready = (r_state == dtq_pkg::S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ov || i_m_tready;
    assign scan_done  = (r_idx == IW'(N)) && !r_rd_v;
    assign bmask      = dtq_pkg::t_mask'(1) << r_bidx;
    assign due_left   = r_due & ~bmask;

    // Lowest free slot for an add.
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
        end
    end

    // Configuration register.
    assign o_pready = 1'b1;
    assign o_prdata = i_paddr[2] ? 32'd0 : r_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= dtq_pkg::DEFAULT_WINDOW;
        end else if (i_psel && i_penable && i_pwrite && o_pready && !i_paddr[2]) begin
            r_window <= i_pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dtq_pkg::S_IDLE;
            r_pending <= 1'b0;
            r_prev    <= '0;
            r_active  <= '0;
            r_ov      <= 1'b0;
            r_rd_v    <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_prev    <= n_prev;
            r_active  <= n_active;
            r_ov      <= n_ov;
            r_rd_v    <= n_rd_v;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_slot       <= n_slot;
        r_interval   <= n_interval;
        r_rec        <= n_rec;
        r_fnow       <= n_fnow;
        r_now        <= n_now;
        r_repeats    <= n_repeats;
        r_due        <= n_due;
        r_rd_idx     <= n_rd_idx;
        r_best       <= n_best;
        r_found      <= n_found;
        r_bidx       <= n_bidx;
        r_first      <= n_first;
        r_tmp        <= n_tmp;
        r_roll_a     <= n_roll_a;
        r_roll       <= n_roll;
        r_more       <= n_more;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_delay  <= n_res_delay;
        r_res_wake   <= n_res_wake;
        r_o_status   <= n_o_status;
        r_o_slot     <= n_o_slot;
        r_o_fired    <= n_o_fired;
        r_o_delay    <= n_o_delay;
        r_o_ht       <= n_o_ht;
        r_o_wake     <= n_o_wake;
        r_o_last     <= n_o_last;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_slot       = r_slot;
        n_interval   = r_interval;
        n_rec        = r_rec;
        n_fnow       = r_fnow;
        n_now        = r_now;
        n_prev       = r_prev;
        n_pending    = r_pending;
        n_active     = r_active;
        n_repeats    = r_repeats;
        n_due        = r_due;
        n_idx        = r_idx;
        n_rd_v       = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_best       = r_best;
        n_found      = r_found;
        n_bidx       = r_bidx;
        n_first      = r_first;
        n_tmp        = r_tmp;
        n_roll_a     = r_roll_a;
        n_roll       = r_roll;
        n_more       = r_more;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_delay  = r_res_delay;
        n_res_wake   = r_res_wake;
        n_ov         = r_ov && !i_m_tready;
        n_o_status   = r_o_status;
        n_o_slot     = r_o_slot;
        n_o_fired    = r_o_fired;
        n_o_delay    = r_o_delay;
        n_o_ht       = r_o_ht;
        n_o_wake     = r_o_wake;
        n_o_last     = r_o_last;
        alu_op       = dtq_pkg::ALU_SUB;
        alu_a        = rd_dl;
        alu_b        = r_best;
        mem_wr       = '{en_dl: 1'b0, en_per: 1'b0, addr: r_slot,
                         dl: alu_res, per: r_interval};
        raddr        = r_slot;

        // Slot scans issue one read address a cycle; its data is used in the next cycle.
        if ((r_state == dtq_pkg::S_WSCAN) || (r_state == dtq_pkg::S_QSCAN) ||
            (r_state == dtq_pkg::S_DSCAN) || (r_state == dtq_pkg::S_SSCAN)) begin
            raddr = r_idx[SW-1:0];
            if (r_idx != IW'(N)) begin
                n_idx    = r_idx + IW'(1);
                n_rd_v   = 1'b1;
                n_rd_idx = r_idx[SW-1:0];
            end
        end

        case (r_state)
            dtq_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_op         = dtq_pkg::t_op'(i_s_tuser);
                    n_slot       = i_s_tdata[4:0];
                    n_interval   = i_s_tdata[36:5];
                    n_rec        = i_s_tdata[37];
                    n_fnow       = i_s_tdata[38];
                    n_now        = i_s_tdata[102:39];
                    n_res_status = dtq_pkg::ST_NONE;
                    n_res_slot   = '0;
                    n_res_delay  = '0;
                    n_res_wake   = 1'b0;
                    n_idx        = '0;
                    n_found      = 1'b0;
                    n_state      = dtq_pkg::S_EMIT;
                    case (dtq_pkg::t_op'(i_s_tuser))
                        dtq_pkg::OP_ADD: n_state = dtq_pkg::S_ADD;
                        dtq_pkg::OP_CANCEL: begin
                            if (r_active[i_s_tdata[4:0]]) begin
                                n_active[i_s_tdata[4:0]] = 1'b0;
                                n_res_status = dtq_pkg::ST_OK;
                            end
                        end
                        dtq_pkg::OP_REFRESH: begin
                            if (r_active[i_s_tdata[4:0]]) begin
                                n_state = dtq_pkg::S_RD;
                            end
                        end
                        dtq_pkg::OP_RESET: n_state = dtq_pkg::S_RD;
                        dtq_pkg::OP_QUERY: begin
                            n_pending = 1'b0;
                            n_state   = dtq_pkg::S_QSCAN;
                        end
                        dtq_pkg::OP_EXPIRE: begin
                            if (|r_active) begin
                                n_state = dtq_pkg::S_ROLL1;
                            end
                        end
                        default: n_state = dtq_pkg::S_EMIT;
                    endcase
                end
            end

            dtq_pkg::S_ADD: begin
                alu_op = dtq_pkg::ALU_ADD;
                alu_a  = r_now;
                alu_b  = {{(TW-PW){1'b0}}, r_interval};
                if (free_found) begin
                    mem_wr.en_dl  = 1'b1;
                    mem_wr.en_per = 1'b1;
                    mem_wr.addr   = free_slot;
                    n_active[free_slot]  = 1'b1;
                    n_repeats[free_slot] = r_rec;
                    n_slot       = free_slot;
                    n_best       = alu_res;
                    n_res_slot   = free_slot;
                    n_res_status = dtq_pkg::ST_OK;
                    n_first      = 1'b1;
                    n_state      = r_pending ? dtq_pkg::S_EMIT : dtq_pkg::S_WSCAN;
                end else begin
                    n_res_status = dtq_pkg::ST_FULL;
                    n_state      = dtq_pkg::S_EMIT;
                end
            end

            dtq_pkg::S_RD: begin
                n_state = (r_op == dtq_pkg::OP_REFRESH) ? dtq_pkg::S_REF : dtq_pkg::S_RST1;
            end

            dtq_pkg::S_REF: begin
                alu_op = dtq_pkg::ALU_ADD;
                alu_a  = r_now;
                alu_b  = {{(TW-PW){1'b0}}, rd_per};
                mem_wr.en_dl = 1'b1;
                n_res_status = dtq_pkg::ST_OK;
                n_state      = dtq_pkg::S_EMIT;
            end

            dtq_pkg::S_RST1: begin
                // Old start is deadline minus period.
                alu_b = {{(TW-PW){1'b0}}, rd_per};
                n_tmp = alu_res;
                if ((r_interval == rd_per) && !r_fnow) begin
                    n_res_status = dtq_pkg::ST_OK;
                    n_state      = dtq_pkg::S_EMIT;
                end else if (r_active[r_slot]) begin
                    n_state = dtq_pkg::S_RST2;
                end else begin
                    n_state = dtq_pkg::S_EMIT;
                end
            end

            dtq_pkg::S_RST2: begin
                alu_op = dtq_pkg::ALU_ADD;
                alu_a  = r_fnow ? r_now : r_tmp;
                alu_b  = {{(TW-PW){1'b0}}, r_interval};
                mem_wr.en_dl  = 1'b1;
                mem_wr.en_per = 1'b1;
                n_best       = alu_res;
                n_first      = 1'b1;
                n_res_status = dtq_pkg::ST_OK;
                n_state      = r_pending ? dtq_pkg::S_EMIT : dtq_pkg::S_WSCAN;
            end

            dtq_pkg::S_WSCAN: begin
                // Any other active slot ordered before the target clears first.
                if (r_rd_v && r_active[r_rd_idx] && (r_rd_idx != r_slot) &&
                    (alu_borrow || ((alu_res == '0) && (r_rd_idx < r_slot)))) begin
                    n_first = 1'b0;
                end
                if (scan_done) begin
                    n_res_wake = r_first;
                    if (r_first) begin
                        n_pending = 1'b1;
                    end
                    n_state = dtq_pkg::S_EMIT;
                end
            end

            dtq_pkg::S_QSCAN: begin
                if (r_rd_v && r_active[r_rd_idx] && (!r_found || alu_borrow)) begin
                    n_best  = rd_dl;
                    n_found = 1'b1;
                end
                if (scan_done) begin
                    n_state = dtq_pkg::S_QFIN;
                end
            end

            dtq_pkg::S_QFIN: begin
                alu_a = r_best;
                alu_b = r_now;
                if (r_found) begin
                    n_res_status = dtq_pkg::ST_OK;
                    n_res_delay  = alu_borrow ? '0 : alu_res;
                end else begin
                    n_res_delay = dtq_pkg::ALL_ONES;
                end
                n_state = dtq_pkg::S_EMIT;
            end

            dtq_pkg::S_ROLL1: begin
                alu_a    = r_prev;
                alu_b    = r_now;
                n_tmp    = alu_res;
                n_roll_a = !alu_borrow && (alu_res != '0);
                n_state  = dtq_pkg::S_ROLL2;
            end

            dtq_pkg::S_ROLL2: begin
                // The backward jump exceeds the window when window - jump borrows.
                alu_a   = {{(TW-PW){1'b0}}, r_window};
                alu_b   = r_tmp;
                n_roll  = r_roll_a && alu_borrow;
                n_prev  = r_now;
                n_due   = '0;
                n_idx   = '0;
                n_state = dtq_pkg::S_DSCAN;
            end

            dtq_pkg::S_DSCAN: begin
                alu_a = r_now;
                alu_b = rd_dl;
                if (r_rd_v) begin
                    n_due[r_rd_idx] = r_active[r_rd_idx] && (r_roll || !alu_borrow);
                end
                if (scan_done) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = (r_due == '0) ? dtq_pkg::S_EMIT : dtq_pkg::S_SSCAN;
                end
            end

            dtq_pkg::S_SSCAN: begin
                if (r_rd_v && r_due[r_rd_idx] && (!r_found || alu_borrow)) begin
                    n_best  = rd_dl;
                    n_bidx  = r_rd_idx;
                    n_found = 1'b1;
                end
                if (scan_done) begin
                    n_state = dtq_pkg::S_FIRE;
                end
            end

            dtq_pkg::S_FIRE: begin
                raddr = r_bidx;
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = dtq_pkg::ST_OK;
                    n_o_slot   = r_bidx;
                    n_o_fired  = 1'b1;
                    n_o_delay  = '0;
                    // Every due timer fires in this expire command, so the final flag is known now.
                    n_o_ht     = |(r_active & ~(r_due & ~r_repeats));
                    n_o_wake   = 1'b0;
                    n_o_last   = (due_left == '0);
                    n_due      = due_left;
                    n_more     = (due_left != '0);
                    n_idx      = '0;
                    n_found    = 1'b0;
                    if (r_repeats[r_bidx]) begin
                        n_state = dtq_pkg::S_UPD;
                    end else begin
                        n_active[r_bidx] = 1'b0;
                        n_state = (due_left != '0) ? dtq_pkg::S_SSCAN : dtq_pkg::S_IDLE;
                    end
                end
            end

            dtq_pkg::S_UPD: begin
                alu_op = dtq_pkg::ALU_ADD;
                alu_a  = r_now;
                alu_b  = {{(TW-PW){1'b0}}, rd_per};
                mem_wr.en_dl = 1'b1;
                mem_wr.addr  = r_bidx;
                n_state = r_more ? dtq_pkg::S_SSCAN : dtq_pkg::S_IDLE;
            end

            dtq_pkg::S_EMIT: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = r_res_status;
                    n_o_slot   = r_res_slot;
                    n_o_fired  = 1'b0;
                    n_o_delay  = r_res_delay;
                    n_o_ht     = |r_active;
                    n_o_wake   = r_res_wake;
                    n_o_last   = 1'b1;
                    n_state    = dtq_pkg::S_IDLE;
                end
            end

            default: n_state = dtq_pkg::S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {6'd0, r_o_wake, r_o_ht, r_o_delay, r_o_fired, r_o_slot, r_o_status};

endmodule

// ----- src/dtq_checker.sv -----
// Port-level checker for the deadline timer queue, bound to the top level.
module dtq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [79:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_pready
);
    // A stalled result holds its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // A fired timer reports success and carries no delay.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[7] |-> (o_m_tdata[1:0] == 2'd0) && (o_m_tdata[71:8] == '0))
        else $error("fired result with bad status or delay");

    // A full table always has active timers.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] == 2'd2) |-> o_m_tdata[72] && o_m_tlast)
        else $error("full status without timers");

    // A wakeup only comes with a successful single result and an active timer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[73] |-> (o_m_tdata[1:0] == 2'd0) && o_m_tdata[72] && o_m_tlast)
        else $error("wakeup on a bad result");

    assert property (@(posedge i_clk) o_pready)
        else $error("configuration port not ready");
endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_pready   (o_pready)
);
